@@ hw/rtl/consistent_hash_server_select_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the consistent-hash server selector
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_SERVER_SELECT_TOP_MACROS_SVH
`define CONSISTENT_HASH_SERVER_SELECT_TOP_MACROS_SVH

// same-cycle implication
`define CHS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chs assertion failed (same cycle)");

// next-cycle implication
`define CHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chs assertion failed (next cycle)");

`endif

@@ hw/rtl/chs_pkg.sv @@
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants, codes and interface structs of the server selector.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int RING_DEPTH  = 4096;
  localparam int MAX_SERVERS = 256;

  localparam int HASH_W     = 32;
  localparam int SRV_W      = 8;
  localparam int SLOT_W     = 12;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int NPT_W      = $clog2(RING_DEPTH + 1);
  localparam int CNT_W      = $clog2(MAX_SERVERS + 1);
  localparam int RAM_W      = SRV_W + HASH_W;
  localparam int BIT_W      = $clog2(HASH_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (NPT_W > CNT_W) ? NPT_W : CNT_W;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_type_t;

  typedef enum logic {
    MODE_RING = 1'b0,
    MODE_MOD  = 1'b1
  } dist_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_SERVERS = 2'd1,
    CFG_POINTS  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ALU_CMP = 1'b0,
    ALU_MOD = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [HASH_W-1:0]  ring_value;
    logic [HASH_W-1:0]  hash;
    logic [CNT_W-1:0]   rem;
    logic [CNT_W-1:0]   divisor;
  } alu_req_t;

  typedef struct packed {
    logic               lt;
    logic [CNT_W-1:0]   rem_nxt;
  } alu_rsp_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [RAM_W-1:0]   data;
  } ram_wr_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
  } ram_rd_t;

endpackage

@@ hw/rtl/chs_ram.sv @@
// ----------------------------------------------------------------------------
// chs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/chs_alu.sv @@
// ----------------------------------------------------------------------------
// chs_alu
// Shared 33-bit subtractor: ring point compare or one restoring-division step.
// ----------------------------------------------------------------------------
module chs_alu import chs_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [CNT_W:0]    trial;
  logic [HASH_W-1:0] op_a;
  logic [HASH_W-1:0] op_b;
  logic [HASH_W:0]   diff;

  assign trial = {req.rem, req.hash[HASH_W-1]};

  always_comb begin
    unique case (req.op)
      ALU_CMP: begin
        op_a = req.ring_value;
        op_b = req.hash;
      end
      ALU_MOD: begin
        op_a = HASH_W'(trial);
        op_b = HASH_W'(req.divisor);
      end
    endcase
  end

  assign diff        = {1'b0, op_a} - {1'b0, op_b};
  assign rsp.lt      = diff[HASH_W];
  assign rsp.rem_nxt = diff[HASH_W] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];

endmodule

@@ hw/rtl/chs_ctrl.sv @@
// ----------------------------------------------------------------------------
// chs_ctrl
// Config registers, lookup sequencer (binary search / serial modulo) and
// output word register.
// ----------------------------------------------------------------------------
module chs_ctrl import chs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [HASH_W-1:0]     in_point_value,
  input  logic [SRV_W-1:0]      in_point_server,
  input  logic [HASH_W-1:0]     in_key_hash,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SRV_W-1:0]      out_server_index,
  output logic                  out_table_empty,
  output ram_wr_t               ram_wr,
  output ram_rd_t               ram_rd,
  input  logic [RAM_W-1:0]      ram_rdata,
  output alu_req_t              alu_req,
  input  alu_rsp_t              alu_rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_CMP,
    ST_OWN,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t            state_r;
  logic              mode_r;
  logic [CNT_W-1:0]  servers_r;
  logic [NPT_W-1:0]  points_r;
  logic [HASH_W-1:0] hash_r;
  logic [CNT_W-1:0]  div_r;
  logic [NPT_W-1:0]  npts_r;
  logic [NPT_W-1:0]  lo_r;
  logic [NPT_W-1:0]  hi_r;
  logic [ADDR_W-1:0] mid_r;
  logic [CNT_W-1:0]  rem_r;
  logic [BIT_W-1:0]  bit_r;
  logic [SRV_W-1:0]  sel_r;
  logic              empty_r;
  logic              out_valid_r;
  logic [SRV_W-1:0]  out_server_index_r;
  logic              out_table_empty_r;

  logic              accept;
  logic [CNT_W-1:0]  cnt_sat;
  logic [NPT_W-1:0]  npts_sat;
  logic [NPT_W:0]    mid_sum;
  logic [ADDR_W-1:0] mid;
  logic              search_live;
  logic [ADDR_W-1:0] end_addr;
  logic              fin_load;

  assign in_ready         = (state_r == ST_IDLE);
  assign accept           = in_valid & in_ready;
  assign out_valid        = out_valid_r;
  assign out_server_index = out_server_index_r;
  assign out_table_empty  = out_table_empty_r;

  always_comb begin
    priority if (servers_r == '0) begin
      cnt_sat = CNT_W'(1);
    end else if (servers_r > CNT_W'(MAX_SERVERS)) begin
      cnt_sat = CNT_W'(MAX_SERVERS);
    end else begin
      cnt_sat = servers_r;
    end
  end

  assign npts_sat    = (points_r > NPT_W'(RING_DEPTH)) ? NPT_W'(RING_DEPTH) : points_r;
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid         = mid_sum[ADDR_W:1];
  assign search_live = (lo_r < hi_r);
  // past the last point the ring wraps to slot 0
  assign end_addr    = (hi_r >= npts_r) ? '0 : hi_r[ADDR_W-1:0];
  assign fin_load    = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign ram_wr.en   = accept && (in_req_type == REQ_WRITE) && (32'(in_slot) < RING_DEPTH);
  assign ram_wr.addr = ADDR_W'(in_slot);
  assign ram_wr.data = {in_point_server, in_point_value};
  assign ram_rd.en   = (state_r == ST_ADDR);
  assign ram_rd.addr = search_live ? mid : end_addr;

  assign alu_req.op         = (state_r == ST_DIV) ? ALU_MOD : ALU_CMP;
  assign alu_req.ring_value = ram_rdata[HASH_W-1:0];
  assign alu_req.hash       = hash_r;
  assign alu_req.rem        = rem_r;
  assign alu_req.divisor    = div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_RING;
      servers_r   <= CNT_W'(1);
      points_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MODE:    mode_r    <= cfg_wdata[0];
          CFG_SERVERS: servers_r <= cfg_wdata[CNT_W-1:0];
          CFG_POINTS:  points_r  <= cfg_wdata[NPT_W-1:0];
          default: ;
        endcase
      end

      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_req_type == REQ_LOOKUP)) begin
            hash_r  <= in_key_hash;
            div_r   <= cnt_sat;
            npts_r  <= npts_sat;
            lo_r    <= '0;
            hi_r    <= npts_sat;
            rem_r   <= '0;
            bit_r   <= '1;
            sel_r   <= '0;
            empty_r <= (cnt_sat > CNT_W'(1)) && (mode_r == MODE_RING) && (npts_sat == '0);
            priority if (cnt_sat <= CNT_W'(1)) begin
              state_r <= ST_FIN;
            end else if (mode_r == MODE_MOD) begin
              state_r <= ST_DIV;
            end else if (npts_sat == '0) begin
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_ADDR;
            end
          end
        end
        ST_ADDR: begin
          mid_r   <= mid;
          state_r <= search_live ? ST_CMP : ST_OWN;
        end
        ST_CMP: begin
          if (alu_rsp.lt) begin
            lo_r <= NPT_W'(mid_r) + NPT_W'(1);
          end else begin
            hi_r <= NPT_W'(mid_r);
          end
          state_r <= ST_ADDR;
        end
        ST_OWN: begin
          sel_r   <= ram_rdata[RAM_W-1:HASH_W];
          state_r <= ST_FIN;
        end
        ST_DIV: begin
          hash_r <= hash_r << 1;
          rem_r  <= alu_rsp.rem_nxt;
          bit_r  <= bit_r - BIT_W'(1);
          if (bit_r == '0) begin
            sel_r   <= alu_rsp.rem_nxt[SRV_W-1:0];
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            out_server_index_r <= sel_r;
            out_table_empty_r  <= empty_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/consistent_hash_server_select_top.sv @@
// ----------------------------------------------------------------------------
// consistent_hash_server_select_top
// Maps a key hash to a server by ring search or by modulo server count.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_ready   | write point or look up hash
//   out_    | output    | out_valid/out_ready | server index, empty flag
//   cfg_    | input     | cfg_we              | mode, server count, points
//
// A write word yields no output word and leaves the input ready.
// Lookup: one server or an empty ring goes straight to the output register;
// modulo takes one remainder bit per cycle through the shared subtractor; a ring
// search runs k halving steps (k up to 13 at 4096 points), each step one RAM read.
// Reset clears control only; ring slots hold nothing until written.
// A pending output word does not block the input; a lookup waits at the end.
// ----------------------------------------------------------------------------
module consistent_hash_server_select_top import chs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [HASH_W-1:0]     in_point_value,
  input  logic [SRV_W-1:0]      in_point_server,
  input  logic [HASH_W-1:0]     in_key_hash,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SRV_W-1:0]      out_server_index,
  output logic                  out_table_empty
);

  ram_wr_t          ram_wr;
  ram_rd_t          ram_rd;
  logic [RAM_W-1:0] ram_rdata;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  chs_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_slot          (in_slot),
    .in_point_value   (in_point_value),
    .in_point_server  (in_point_server),
    .in_key_hash      (in_key_hash),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_server_index (out_server_index),
    .out_table_empty  (out_table_empty),
    .ram_wr           (ram_wr),
    .ram_rd           (ram_rd),
    .ram_rdata        (ram_rdata),
    .alu_req          (alu_req),
    .alu_rsp          (alu_rsp)
  );

  chs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  chs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_rd.en),
    .raddr (ram_rd.addr),
    .rdata (ram_rdata)
  );

endmodule

@@ hw/rtl/chs_checker.sv @@
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the server selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "consistent_hash_server_select_top_macros.svh"

module chs_checker import chs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_req_type,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SRV_W-1:0] out_server_index,
  input logic             out_table_empty
);

  `CHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_server_index) && $stable(out_table_empty))
  `CHS_ASSERT_IMPL(a_empty_zero, out_valid && out_table_empty, out_server_index == '0)
  `CHS_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && (in_req_type == REQ_LOOKUP), !in_ready)
  `CHS_ASSERT_NEXT(a_write_silent, in_valid && in_ready && (in_req_type == REQ_WRITE) && !out_valid, !out_valid)

endmodule

bind consistent_hash_server_select_top chs_checker u_chs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_req_type      (in_req_type),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_server_index (out_server_index),
  .out_table_empty  (out_table_empty)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the consistent-hash server selector. Ring points are
// written and hashes looked up in ring and modulo mode over many register
// settings, including rings of varied size, saturated server counts, an empty
// ring and a single server. Every lookup is predicted at acceptance and each
// output word is checked field by field, with random bursts on the sender and
// a stall pattern on the receiver.
// ----------------------------------------------------------------------------
module tb_top;
  import chs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 40;
  localparam int PHASES      = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  class ring_lookup_checker;
    typedef struct packed {
      logic [SRV_W-1:0] server;
      logic             empty;
    } choice_t;

    logic [HASH_W-1:0] ring_value [RING_DEPTH];
    logic [SRV_W-1:0]  ring_owner [RING_DEPTH];
    dist_mode_t        mode;
    logic [CNT_W-1:0]  servers;
    logic [NPT_W-1:0]  points;
    choice_t           expected_choices [$];
    int                errors;
    int                lookups;
    int                writes;

    function new();
      mode    = MODE_RING;
      servers = 1;
      points  = 0;
      errors  = 0;
      lookups = 0;
      writes  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:    mode    = dist_mode_t'(data[0]);
        CFG_SERVERS: servers = data[CNT_W-1:0];
        CFG_POINTS:  points  = data[NPT_W-1:0];
        default: ;
      endcase
    endfunction

    function choice_t pick_server(logic [HASH_W-1:0] hash);
      int unsigned count;
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      choice_t     sel;
      sel   = '0;
      count = servers;
      if (count > MAX_SERVERS) count = MAX_SERVERS;
      if (count > 1) begin
        if (mode == MODE_RING) begin
          n = points;
          if (n > RING_DEPTH) n = RING_DEPTH;
          if (n == 0) begin
            sel.empty = 1'b1;
          end else begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (ring_value[mid] < hash) lo = mid + 1;
              else hi = mid;
            end
            if (hi >= n) hi = 0;
            sel.server = ring_owner[hi];
          end
        end else begin
          sel.server = SRV_W'(hash % count);
        end
      end
      return sel;
    endfunction

    function void note_word(logic req, logic [SLOT_W-1:0] slot, logic [HASH_W-1:0] pval,
                            logic [SRV_W-1:0] psrv, logic [HASH_W-1:0] hash);
      if (req == REQ_WRITE) begin
        ring_value[slot] = pval;
        ring_owner[slot] = psrv;
        writes++;
      end else begin
        expected_choices.push_back(pick_server(hash));
        lookups++;
      end
    endfunction

    function void check_choice(logic [SRV_W-1:0] server, logic empty);
      choice_t want;
      if (expected_choices.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, server_index %0d table_empty %0b",
                 $time, server, empty);
        return;
      end
      want = expected_choices.pop_front();
      if (server !== want.server) begin
        errors++;
        $display("%0t: server_index expected %0d actual %0d", $time, want.server, server);
      end
      if (empty !== want.empty) begin
        errors++;
        $display("%0t: table_empty expected %0b actual %0b", $time, want.empty, empty);
      end
    endfunction
  endclass

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic                  in_req_type     = 1'b0;
  logic [SLOT_W-1:0]     in_slot         = '0;
  logic [HASH_W-1:0]     in_point_value  = '0;
  logic [SRV_W-1:0]      in_point_server = '0;
  logic [HASH_W-1:0]     in_key_hash     = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [SRV_W-1:0]      out_server_index;
  logic                  out_table_empty;

  ring_lookup_checker book;
  logic [HASH_W-1:0]  ring_pts [$];
  int                 ring_top      = 0;
  int                 burst_left    = 0;
  int                 settings_done = 0;
  int                 cycles        = 0;
  logic [15:0]        stall_pattern = 16'hFFFF;
  int                 stall_pos     = 0;

  always #4 clk = ~clk;

  consistent_hash_server_select_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_slot          (in_slot),
    .in_point_value   (in_point_value),
    .in_point_server  (in_point_server),
    .in_key_hash      (in_key_hash),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_server_index (out_server_index),
    .out_table_empty  (out_table_empty)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        book.note_word(in_req_type, in_slot, in_point_value, in_point_server, in_key_hash);
      if (out_valid && out_ready)
        book.check_choice(out_server_index, out_table_empty);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout, %0d words outstanding", book.expected_choices.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern, reloaded at random after its last bit is used
  always @(posedge clk) begin
    out_ready <= stall_pattern[stall_pos];
    if (stall_pos == 15) begin
      stall_pos <= 0;
      case ($urandom_range(0, 3))
        0: stall_pattern <= 16'hFFFF;
        1: stall_pattern <= 16'($urandom) | 16'($urandom);
        2: stall_pattern <= 16'($urandom);
        default: stall_pattern <= 16'($urandom) & 16'($urandom);
      endcase
    end else begin
      stall_pos <= stall_pos + 1;
    end
  end

  task automatic send_word(logic req, logic [SLOT_W-1:0] slot, logic [HASH_W-1:0] pval,
                           logic [SRV_W-1:0] psrv, logic [HASH_W-1:0] hash);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_slot         <= slot;
    in_point_value  <= pval;
    in_point_server <= psrv;
    in_key_hash     <= hash;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic lookup(logic [HASH_W-1:0] hash);
    send_word(REQ_LOOKUP, SLOT_W'($urandom), $urandom, SRV_W'($urandom), hash);
  endtask

  task automatic put_point(logic [SLOT_W-1:0] slot, logic [HASH_W-1:0] pval,
                           logic [SRV_W-1:0] psrv);
    send_word(REQ_WRITE, slot, pval, psrv, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.expected_choices.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    book.set_reg(idx, data);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] mode_w, logic [CFG_DATA_W-1:0] servers_w,
                           int unsigned npts, bit poke_spare);
    write_reg(CFG_MODE, mode_w);
    write_reg(CFG_SERVERS, servers_w);
    write_reg(CFG_POINTS, CFG_DATA_W'(npts));
    if (poke_spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_done++;
  endtask

  // upper bits are beyond the register and must be dropped
  function automatic logic [CFG_DATA_W-1:0] mode_word(dist_mode_t m);
    return {(CFG_DATA_W-1)'($urandom), m};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] server_word(int unsigned count);
    return {(CFG_DATA_W-CNT_W)'($urandom), CNT_W'(count)};
  endfunction

  function automatic logic [HASH_W-1:0] pick_hash();
    logic [HASH_W-1:0] p;
    int unsigned       sel;
    sel = $urandom_range(0, 9);
    if (ring_pts.size() == 0 || sel < 3) return $urandom;
    p = ring_pts[$urandom_range(0, ring_pts.size() - 1)];
    case (sel)
      3, 4: return p;
      5: return p - 1;
      6: return p + 1;
      7: return '0;
      8: return '1;
      default: return ring_pts[ring_pts.size() - 1] + 1;
    endcase
  endfunction

  // sorted ring in slots 0..k-1, sometimes with a tie and the extreme values
  task automatic build_ring(int k);
    logic [HASH_W-1:0] vals [$];
    int                j;
    repeat (k) vals.push_back($urandom);
    vals.sort();
    if ($urandom_range(0, 5) == 0) begin
      vals[0]     = '0;
      vals[k - 1] = '1;
    end
    if (k > 1 && $urandom_range(0, 3) == 0) begin
      j       = $urandom_range(1, k - 1);
      vals[j] = vals[j - 1];
    end
    ring_pts = vals;
    if (k > ring_top) ring_top = k;
    for (int s = 0; s < k; s++) put_point(SLOT_W'(s), vals[s], SRV_W'($urandom));
  endtask

  initial begin
    int          k;
    int          nlook;
    int unsigned npts;
    int unsigned cnt;
    dist_mode_t  m;

    book = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single server at reset
    lookup('0);
    lookup('1);
    // zero server count behaves as one
    drain();
    configure(mode_word(MODE_RING), server_word(0), 0, 1'b1);
    lookup($urandom);
    // empty ring
    drain();
    configure(mode_word(MODE_RING), server_word(2), 0, 1'b0);
    lookup('0);
    lookup('1);
    // modulo, full and saturated server counts
    drain();
    configure(mode_word(MODE_MOD), server_word(256), 0, 1'b0);
    lookup('1);
    lookup('0);
    drain();
    configure(mode_word(MODE_MOD), server_word(511), 0, 1'b0);
    lookup(32'h1234_5678);
    drain();
    configure(mode_word(MODE_MOD), server_word(3), 0, 1'b0);
    lookup('1);
    // small ring with extreme values, plus the top slot
    put_point(0, '0, 8'hFF);
    put_point(1, 32'h0000_1000, 8'h00);
    put_point(2, 32'h8000_0000, 8'h07);
    put_point(3, '1, 8'h80);
    put_point('1, $urandom, SRV_W'($urandom));
    ring_pts = '{32'h0, 32'h0000_1000, 32'h8000_0000, 32'hFFFF_FFFF};
    ring_top = 4;
    drain();
    configure(mode_word(MODE_RING), server_word(256), 4, 1'b0);
    lookup('0);
    lookup(32'h1);
    lookup(32'h0000_1000);
    lookup(32'h8000_0001);
    lookup('1);
    // past the last point wraps to slot 0
    drain();
    configure(mode_word(MODE_RING), server_word(9), 3, 1'b0);
    lookup('1);
    lookup(32'h8000_0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 24);
        build_ring(k);
      end
      drain();
      m = ($urandom_range(0, 2) == 0) ? MODE_MOD : MODE_RING;
      case ($urandom_range(0, 11))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = 2;
        3: cnt = 256;
        4: cnt = $urandom_range(257, 511);
        default: cnt = $urandom_range(2, 256);
      endcase
      // only slots already written are ever searched
      case ($urandom_range(0, 9))
        0: npts = 0;
        1: npts = $urandom_range(1, ring_top);
        2: npts = ring_top;
        default: npts = ring_pts.size();
      endcase
      configure(mode_word(m), server_word(cnt), npts, $urandom_range(0, 3) == 0);
      nlook = $urandom_range(20, 40);
      repeat (nlook) begin
        if ($urandom_range(0, 9) == 0)
          put_point(SLOT_W'($urandom), $urandom, SRV_W'($urandom));
        lookup(pick_hash());
      end
    end

    drain();
    $display("Covered %0d ring point writes and %0d lookups over %0d register settings,",
             book.writes, book.lookups, settings_done);
    $display("with rings of varied size, empty ring, modulo mode and saturated counts.");
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
